// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: forbidden condition");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`endif

// ===== hw/rtl/svbp_pkg.sv =====
package svbp_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_PARAM  = 2'd1,
        CMD_RXBYTE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        RES_TX      = 2'd0,
        RES_RXPARAM = 2'd1,
        RES_DONE    = 2'd2
    } t_res_kind;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TXPARAM   = 3'd1,
        PH_WAITFIRST = 3'd2,
        PH_HEADER    = 3'd3,
        PH_RXPARAM   = 3'd4,
        PH_RXSUM     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        JOB_START = 2'd0,
        JOB_PARAM = 2'd1,
        JOB_RX    = 2'd2,
        JOB_DONE  = 2'd3
    } t_job_kind;

    localparam logic [7:0] CFG_FIRST_TIMEOUT = 8'd0;
    localparam logic [7:0] CFG_BYTE_TIMEOUT  = 8'd1;
    localparam logic [7:0] CFG_BROADCAST     = 8'd2;
    localparam logic [7:0] CFG_PING          = 8'd3;

    localparam logic [7:0] RST_FIRST_TIMEOUT = 8'd110;
    localparam logic [7:0] RST_BYTE_TIMEOUT  = 8'd100;
    localparam logic [7:0] RST_BROADCAST     = 8'd254;
    localparam logic [7:0] RST_PING          = 8'd1;

    localparam logic [7:0] HDR_BYTE  = 8'hff;
    localparam logic [7:0] LEN_EXTRA = 8'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] first_timeout;
        logic [7:0] byte_timeout;
        logic [7:0] broadcast;
        logic [7:0] ping;
    } t_cfg;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] idx;
        logic [7:0] sum;
        logic       has_sum;
        logic       has_done;
        logic [7:0] status;
        logic       timed_out;
        logic       hdr_err;
        logic       id_err;
        logic       cks_err;
    } t_job;

    typedef struct packed {
        t_res_kind  result_kind;
        logic [7:0] byte_value;
        logic [7:0] param_index;
        logic [7:0] device_status;
        logic       timed_out;
        logic       header_error;
        logic       id_mismatch;
        logic       checksum_error;
        logic       last;
    } t_result;

endpackage

// ===== hw/rtl/svbp_if.sv =====
interface svbp_in_if;
    import svbp_pkg::*;
    logic       valid;
    logic       ready;
    t_cmd       command;
    logic [7:0] module_id;
    logic [7:0] instruction_code;
    logic [7:0] param_count;
    logic [7:0] data_byte;

    modport source (output valid, command, module_id, instruction_code, param_count,
                    data_byte, input ready);
    modport sink (input valid, command, module_id, instruction_code, param_count,
                  data_byte, output ready);
endinterface

interface svbp_out_if;
    import svbp_pkg::*;
    logic       valid;
    logic       ready;
    t_res_kind  result_kind;
    logic [7:0] byte_value;
    logic [7:0] param_index;
    logic [7:0] device_status;
    logic       timed_out;
    logic       header_error;
    logic       id_mismatch;
    logic       checksum_error;
    logic       last;

    modport source (output valid, result_kind, byte_value, param_index, device_status,
                    timed_out, header_error, id_mismatch, checksum_error, last,
                    input ready);
    modport sink (input valid, result_kind, byte_value, param_index, device_status,
                  timed_out, header_error, id_mismatch, checksum_error, last,
                  output ready);
endinterface

interface svbp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/svbp_front.sv =====
module svbp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    svbp_in_if.sink         i_cmd,
    input  svbp_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output svbp_pkg::t_job  o_job
);
    import svbp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_target, n_target;
    logic [7:0] r_ins, n_ins;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_sum, n_sum;
    logic [2:0] r_hp, n_hp;
    logic [7:0] r_idx, n_idx;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_status, n_status;
    logic [1:0] r_flags, n_flags;

    logic accept;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_target <= '0;
            r_ins    <= '0;
            r_rem    <= '0;
            r_sum    <= '0;
            r_hp     <= '0;
            r_idx    <= '0;
            r_tick   <= '0;
            r_status <= '0;
            r_flags  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_target <= n_target;
            r_ins    <= n_ins;
            r_rem    <= n_rem;
            r_sum    <= n_sum;
            r_hp     <= n_hp;
            r_idx    <= n_idx;
            r_tick   <= n_tick;
            r_status <= n_status;
            r_flags  <= n_flags;
        end
    end

    always_comb begin
        logic       waiting;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] rem;
        logic       reply;
        t_phase     ph;
        logic [2:0] hp;
        logic [1:0] flags;
        logic [7:0] status;

        n_phase  = r_phase;
        n_target = r_target;
        n_ins    = r_ins;
        n_rem    = r_rem;
        n_sum    = r_sum;
        n_hp     = r_hp;
        n_idx    = r_idx;
        n_tick   = r_tick;
        n_status = r_status;
        n_flags  = r_flags;
        o_push   = 1'b0;
        o_job    = '0;

        waiting = (r_phase == PH_WAITFIRST) || (r_phase == PH_HEADER) ||
                  (r_phase == PH_RXPARAM) || (r_phase == PH_RXSUM);
        len     = i_cmd.param_count + LEN_EXTRA;
        sum     = '0;
        rem     = '0;
        reply   = 1'b0;
        ph      = r_phase;
        hp      = r_hp;
        flags   = r_flags;
        status  = r_status;

        if (accept) begin
            case (i_cmd.command)
                CMD_START: begin
                    if (r_phase == PH_IDLE) begin
                        sum        = i_cmd.module_id + len + i_cmd.instruction_code;
                        reply      = (i_cmd.module_id != i_cfg.broadcast) ||
                                     (i_cmd.instruction_code == i_cfg.ping);
                        n_target   = i_cmd.module_id;
                        n_ins      = i_cmd.instruction_code;
                        n_rem      = i_cmd.param_count;
                        n_sum      = sum;
                        o_push     = 1'b1;
                        o_job.kind = JOB_START;
                        o_job.b0   = i_cmd.module_id;
                        o_job.b1   = len;
                        o_job.b2   = i_cmd.instruction_code;
                        o_job.sum  = ~sum;
                        if (i_cmd.param_count == '0) begin
                            o_job.has_sum = 1'b1;
                            if (reply) begin
                                n_phase = PH_WAITFIRST;
                                n_tick  = i_cfg.first_timeout;
                            end else begin
                                n_phase        = PH_IDLE;
                                o_job.has_done = 1'b1;
                            end
                        end else begin
                            n_phase = PH_TXPARAM;
                        end
                    end
                end
                CMD_PARAM: begin
                    if (r_phase == PH_TXPARAM) begin
                        sum        = r_sum + i_cmd.data_byte;
                        rem        = r_rem - 8'd1;
                        reply      = (r_target != i_cfg.broadcast) || (r_ins == i_cfg.ping);
                        n_sum      = sum;
                        n_rem      = rem;
                        o_push     = 1'b1;
                        o_job.kind = JOB_PARAM;
                        o_job.b2   = i_cmd.data_byte;
                        o_job.sum  = ~sum;
                        if (rem == '0) begin
                            o_job.has_sum = 1'b1;
                            if (reply) begin
                                n_phase = PH_WAITFIRST;
                                n_tick  = i_cfg.first_timeout;
                            end else begin
                                n_phase        = PH_IDLE;
                                o_job.has_done = 1'b1;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (waiting) begin
                        if (r_tick == '0) begin
                            n_phase         = PH_IDLE;
                            o_push          = 1'b1;
                            o_job.kind      = JOB_DONE;
                            o_job.timed_out = 1'b1;
                        end else begin
                            n_tick = r_tick - 8'd1;
                        end
                    end
                end
                default: begin
                    if (waiting) begin
                        n_tick = i_cfg.byte_timeout;
                        if (r_phase == PH_WAITFIRST) begin
                            ph     = PH_HEADER;
                            hp     = '0;
                            flags  = '0;
                            status = '0;
                        end
                        case (ph)
                            PH_HEADER: begin
                                n_phase = PH_HEADER;
                                case (hp)
                                    3'd0, 3'd1: begin
                                        if (i_cmd.data_byte != HDR_BYTE) begin
                                            flags[0] = 1'b1;
                                        end
                                    end
                                    3'd2: begin
                                        if (i_cmd.data_byte != r_target) begin
                                            flags[1] = 1'b1;
                                        end
                                        n_sum = i_cmd.data_byte;
                                    end
                                    3'd3: begin
                                        n_sum = r_sum + i_cmd.data_byte;
                                        n_rem = (i_cmd.data_byte < LEN_EXTRA) ? 8'd0 :
                                                i_cmd.data_byte - LEN_EXTRA;
                                    end
                                    default: begin
                                        n_sum   = r_sum + i_cmd.data_byte;
                                        status  = i_cmd.data_byte;
                                        n_idx   = '0;
                                        n_phase = (r_rem != '0) ? PH_RXPARAM : PH_RXSUM;
                                    end
                                endcase
                                n_hp     = hp + 3'd1;
                                n_flags  = flags;
                                n_status = status;
                            end
                            PH_RXPARAM: begin
                                rem        = r_rem - 8'd1;
                                o_push     = 1'b1;
                                o_job.kind = JOB_RX;
                                o_job.b2   = i_cmd.data_byte;
                                o_job.idx  = r_idx;
                                n_sum      = r_sum + i_cmd.data_byte;
                                n_idx      = r_idx + 8'd1;
                                n_rem      = rem;
                                if (rem == '0) begin
                                    n_phase = PH_RXSUM;
                                end
                            end
                            default: begin
                                n_phase       = PH_IDLE;
                                o_push        = 1'b1;
                                o_job.kind    = JOB_DONE;
                                o_job.status  = r_status;
                                o_job.hdr_err = r_flags[0];
                                o_job.id_err  = r_flags[1];
                                o_job.cks_err = i_cmd.data_byte != ~r_sum;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/svbp_queue.sv =====
`include "assert_macros.svh"

module svbp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  svbp_pkg::t_job  i_data,
    input  logic            i_pop,
    output svbp_pkg::t_job  o_data,
    output logic            o_full,
    output logic            o_empty
);
    import svbp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR   = PW'(QUEUE_DEPTH - 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_data  = r_mem[r_rd];
    assign o_full  = r_count == FULL_COUNT;
    assign o_empty = r_count == '0;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && (r_count == FULL_COUNT))
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_count == '0))

endmodule

// ===== hw/rtl/svbp_back.sv =====
`include "assert_macros.svh"

module svbp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svbp_pkg::t_job  i_job,
    input  logic            i_q_empty,
    output logic            o_pop,
    svbp_out_if.source      o_res
);
    import svbp_pkg::*;

    localparam logic [2:0] SLOT_INS  = 3'd4;
    localparam logic [2:0] SLOT_SUM  = 3'd5;
    localparam logic [2:0] SLOT_DONE = 3'd6;

    logic       r_busy, n_busy;
    t_job       r_job, n_job;
    logic [2:0] r_slot, n_slot;
    logic [2:0] r_end, n_end;
    logic       r_ov, n_ov;
    t_result    r_out, n_out;

    logic out_free;
    logic finishing;

    function automatic t_result beat(input t_job job, input logic [2:0] slot);
        t_result res;
        res = '0;
        case (job.kind)
            JOB_RX: begin
                res.result_kind = RES_RXPARAM;
                res.byte_value  = job.b2;
                res.param_index = job.idx;
            end
            JOB_DONE: begin
                res.result_kind    = RES_DONE;
                res.device_status  = job.status;
                res.timed_out      = job.timed_out;
                res.header_error   = job.hdr_err;
                res.id_mismatch    = job.id_err;
                res.checksum_error = job.cks_err;
                res.last           = 1'b1;
            end
            default: begin
                res.result_kind = RES_TX;
                case (slot)
                    3'd0, 3'd1: res.byte_value = HDR_BYTE;
                    3'd2:       res.byte_value = job.b0;
                    3'd3:       res.byte_value = job.b1;
                    SLOT_INS:   res.byte_value = job.b2;
                    SLOT_SUM:   res.byte_value = job.sum;
                    default: begin
                        res.result_kind = RES_DONE;
                        res.last        = 1'b1;
                    end
                endcase
            end
        endcase
        return res;
    endfunction

    assign out_free  = !r_ov || o_res.ready;
    assign finishing = r_busy && out_free && (r_slot == r_end);
    assign o_pop     = !i_q_empty && (!r_busy || finishing);

    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        n_slot = r_slot;
        n_end  = r_end;
        n_ov   = r_ov;
        n_out  = r_out;

        if (out_free) begin
            n_ov = r_busy;
            if (r_busy) begin
                n_out  = beat(r_job, r_slot);
                n_slot = r_slot + 3'd1;
                if (r_slot == r_end) begin
                    n_busy = 1'b0;
                end
            end
        end

        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
            case (i_job.kind)
                JOB_START: n_slot = '0;
                JOB_PARAM: n_slot = SLOT_INS;
                default:   n_slot = '0;
            endcase
            case (i_job.kind)
                JOB_START, JOB_PARAM: begin
                    n_end = i_job.has_done ? SLOT_DONE :
                            i_job.has_sum ? SLOT_SUM : SLOT_INS;
                end
                default: n_end = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_slot <= n_slot;
        r_end  <= n_end;
        r_out  <= n_out;
    end

    assign o_res.valid          = r_ov;
    assign o_res.result_kind    = r_out.result_kind;
    assign o_res.byte_value     = r_out.byte_value;
    assign o_res.param_index    = r_out.param_index;
    assign o_res.device_status  = r_out.device_status;
    assign o_res.timed_out      = r_out.timed_out;
    assign o_res.header_error   = r_out.header_error;
    assign o_res.id_mismatch    = r_out.id_mismatch;
    assign o_res.checksum_error = r_out.checksum_error;
    assign o_res.last           = r_out.last;

    `ASSERT_IMPLIES(a_slot_range, i_clk, i_rst_n, r_busy, (r_slot <= r_end) && (r_end <= SLOT_DONE))
    `ASSERT_IMPLIES(a_last_is_done, i_clk, i_rst_n, r_ov && r_out.last, r_out.result_kind == RES_DONE)

endmodule

// ===== hw/rtl/servo_bus_packet_transaction_top.sv =====
// Master side of a half-duplex servo bus transaction. A start beat sends the
// packet header, id, length and instruction; parameter beats follow and the
// inverted byte sum goes out as checksum. Unless a broadcast without ping, the
// received bytes are parsed as a status packet: reply parameters come out as
// beats and a done beat with status and error flags closes the transaction.
// Tick beats run the first-byte and per-byte timeouts. An input beat is taken
// whenever the two-entry job queue has room; results leave one beat per cycle
// while the result sink is ready, and the result expander turns each queued
// job into its result beats. Configuration writes are always ready and apply
// the next cycle.
module servo_bus_packet_transaction_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svbp_in_if.sink    i_cmd,
    svbp_cfg_if.sink   i_cfg,
    svbp_out_if.source o_res
);
    import svbp_pkg::*;

    t_cfg r_cfg;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job front_job;
    t_job queue_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_timeout <= RST_FIRST_TIMEOUT;
            r_cfg.byte_timeout  <= RST_BYTE_TIMEOUT;
            r_cfg.broadcast     <= RST_BROADCAST;
            r_cfg.ping          <= RST_PING;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FIRST_TIMEOUT: r_cfg.first_timeout <= i_cfg.data;
                CFG_BYTE_TIMEOUT:  r_cfg.byte_timeout  <= i_cfg.data;
                CFG_BROADCAST:     r_cfg.broadcast     <= i_cfg.data;
                CFG_PING:          r_cfg.ping          <= i_cfg.data;
                default: ;
            endcase
        end
    end

    svbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    svbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (queue_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    svbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (queue_job),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule
